[src/qrt_pkg.sv]
// Shared types and widths for the quaternion rigid transform core.
package qrt_pkg;

    // Vector, translation and result components are signed Q16.16.
    localparam int VEC_W = 32;
    // Quaternion components are signed Q2.14.
    localparam int QW = 16;
    // Rotation matrix elements are signed Q6.16 after rounding.
    localparam int MEL_W = 22;

    // Commands carried with each item.
    localparam logic [1:0] CMD_POINT = 2'd0;
    localparam logic [1:0] CMD_ROT   = 2'd1;
    localparam logic [1:0] CMD_TRANS = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_QUAT_W = 3'd0;
    localparam logic [2:0] REG_QUAT_I = 3'd1;
    localparam logic [2:0] REG_QUAT_J = 3'd2;
    localparam logic [2:0] REG_QUAT_K = 3'd3;
    localparam logic [2:0] REG_POS_X  = 3'd4;
    localparam logic [2:0] REG_POS_Y  = 3'd5;
    localparam logic [2:0] REG_POS_Z  = 3'd6;

    typedef logic signed [VEC_W-1:0] t_vec;
    typedef logic signed [QW-1:0]    t_quat;
    typedef logic signed [MEL_W-1:0] t_mel;

    // One row of the rotation matrix.
    typedef struct packed {
        t_mel c0;
        t_mel c1;
        t_mel c2;
    } t_mrow;

    // The whole rotation matrix, row by row.
    typedef struct packed {
        t_mrow r0;
        t_mrow r1;
        t_mrow r2;
    } t_mat;

    // Load enables for the multiply and sum stages of a row unit.
    typedef struct packed {
        logic s4;
        logic s5;
    } t_stage_en;

endpackage

[src/qrt_matrix.sv]
// Two-stage rotation matrix builder driven by the quaternion registers.
module qrt_matrix (
    input  logic          i_clk,
    input  qrt_pkg::t_quat i_quat_w,
    input  qrt_pkg::t_quat i_quat_i,
    input  qrt_pkg::t_quat i_quat_j,
    input  qrt_pkg::t_quat i_quat_k,
    output qrt_pkg::t_mat  o_mat
);

    localparam logic signed [33:0] ONE_Q28 = 34'sd268435456;
    localparam logic signed [33:0] HALF_Q12 = 34'sd2048;

    // Products of quaternion components, exact at scale 2^-28.
    logic signed [31:0] r_ii, r_jj, r_kk, r_ij, r_ik, r_jk, r_iw, r_jw, r_kw;
    qrt_pkg::t_mat r_mat;
    qrt_pkg::t_mat n_mat;

    // Twice a sum or difference of two products.
    function automatic logic signed [33:0] twice(input logic signed [31:0] a,
                                                 input logic signed [31:0] b,
                                                 input logic               sub);
        logic signed [33:0] ea;
        logic signed [33:0] eb;
        ea = 34'(a);
        eb = 34'(b);
        return sub ? ((ea - eb) <<< 1) : ((ea + eb) <<< 1);
    endfunction

    // Round half up from scale 2^-28 to scale 2^-16.
    function automatic qrt_pkg::t_mel to_q16(input logic signed [33:0] e);
        logic signed [33:0] t;
        t = e + HALF_Q12;
        return qrt_pkg::t_mel'(t[33:12]);
    endfunction

    // Stage one: all nine component products.
    always_ff @(posedge i_clk) begin
        r_ii <= 32'(i_quat_i) * 32'(i_quat_i);
        r_jj <= 32'(i_quat_j) * 32'(i_quat_j);
        r_kk <= 32'(i_quat_k) * 32'(i_quat_k);
        r_ij <= 32'(i_quat_i) * 32'(i_quat_j);
        r_ik <= 32'(i_quat_i) * 32'(i_quat_k);
        r_jk <= 32'(i_quat_j) * 32'(i_quat_k);
        r_iw <= 32'(i_quat_i) * 32'(i_quat_w);
        r_jw <= 32'(i_quat_j) * 32'(i_quat_w);
        r_kw <= 32'(i_quat_k) * 32'(i_quat_w);
    end

    // Stage two: combine the products into the nine elements and round them.
    always_comb begin
        n_mat.r0.c0 = to_q16(ONE_Q28 - twice(r_jj, r_kk, 1'b0));
        n_mat.r0.c1 = to_q16(twice(r_ij, r_kw, 1'b0));
        n_mat.r0.c2 = to_q16(twice(r_ik, r_jw, 1'b1));
        n_mat.r1.c0 = to_q16(twice(r_ij, r_kw, 1'b1));
        n_mat.r1.c1 = to_q16(ONE_Q28 - twice(r_ii, r_kk, 1'b0));
        n_mat.r1.c2 = to_q16(twice(r_jk, r_iw, 1'b0));
        n_mat.r2.c0 = to_q16(twice(r_ik, r_jw, 1'b0));
        n_mat.r2.c1 = to_q16(twice(r_jk, r_iw, 1'b1));
        n_mat.r2.c2 = to_q16(ONE_Q28 - twice(r_ii, r_jj, 1'b0));
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_mat = r_mat;

endmodule

[src/qrt_row.sv]
// One output component: three products, a sum with optional translation, round and clamp.
module qrt_row (
    input  logic               i_clk,
    input  qrt_pkg::t_stage_en i_en,
    input  qrt_pkg::t_mrow     i_row,
    input  qrt_pkg::t_vec      i_vec_x,
    input  qrt_pkg::t_vec      i_vec_y,
    input  qrt_pkg::t_vec      i_vec_z,
    input  logic               i_add_pos,
    input  qrt_pkg::t_vec      i_pos,
    output qrt_pkg::t_vec      o_res
);

    localparam int PROD_W = qrt_pkg::MEL_W + qrt_pkg::VEC_W;
    localparam int SUM_W  = PROD_W + 3;
    localparam int RES_W  = SUM_W - 16;
    localparam logic signed [SUM_W-1:0] HALF_Q32 = SUM_W'(32768);

    logic signed [PROD_W-1:0] r_px, r_py, r_pz;
    logic                     r_add_pos;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  pos_s;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SUM_W-1:0]  rnd;
    logic signed [RES_W-1:0]  res_q;

    // Multiply stage: element times component, exact at scale 2^-32.
    always_ff @(posedge i_clk) begin
        if (i_en.s4) begin
            r_px      <= PROD_W'(i_row.c0) * PROD_W'(i_vec_x);
            r_py      <= PROD_W'(i_row.c1) * PROD_W'(i_vec_y);
            r_pz      <= PROD_W'(i_row.c2) * PROD_W'(i_vec_z);
            r_add_pos <= i_add_pos;
        end
    end

    // Sum stage: the translation enters at the same scale.
    always_comb begin
        pos_s = SUM_W'(i_pos) <<< 16;
        n_sum = SUM_W'(r_px) + SUM_W'(r_py) + SUM_W'(r_pz);
        if (r_add_pos) begin
            n_sum = n_sum + pos_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s5) begin
            r_sum <= n_sum;
        end
    end

    // Round half up to Q16.16 and clamp to the 32-bit range.
    always_comb begin
        rnd   = r_sum + HALF_Q32;
        res_q = RES_W'(rnd[SUM_W-1:16]);
        if (res_q[RES_W-1:qrt_pkg::VEC_W-1] == '0 ||
            res_q[RES_W-1:qrt_pkg::VEC_W-1] == '1) begin
            o_res = qrt_pkg::t_vec'(res_q[qrt_pkg::VEC_W-1:0]);
        end else if (res_q[RES_W-1]) begin
            o_res = {1'b1, {(qrt_pkg::VEC_W-1){1'b0}}};
        end else begin
            o_res = {1'b0, {(qrt_pkg::VEC_W-1){1'b1}}};
        end
    end

endmodule

[src/quaternion_rigid_transform_core.sv]
// Top level of the quaternion rigid transform core: registers, pipeline control, output stage.
//
//  Channel  | Direction | Handshake            | Payload
//  ---------+-----------+----------------------+------------------------------------
//  input    | in        | i_valid / o_stall    | i_cmd, i_vec_x, i_vec_y, i_vec_z
//  result   | out       | o_valid / i_stall    | o_out_x, o_out_y, o_out_z
//  config   | in        | i_cfg_we (no wait)   | i_cfg_idx, i_cfg_data
//
// Six register stages: input capture, translate add, alignment with the matrix
// builder, multiply, sum, round/clamp into the output register. One item is
// accepted per cycle while the result channel is not stalled.
// The matrix builder follows a quaternion write through its product and element registers.
// Synchronous active-low reset clears the valid bits and loads the register defaults.
// Each stage holds only while it is full and the stage after it holds, so bubbles close up.
module quaternion_rigid_transform_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_cmd,
    input  qrt_pkg::t_vec        i_vec_x,
    input  qrt_pkg::t_vec        i_vec_y,
    input  qrt_pkg::t_vec        i_vec_z,
    output logic                 o_valid,
    input  logic                 i_stall,
    output qrt_pkg::t_vec        o_out_x,
    output qrt_pkg::t_vec        o_out_y,
    output qrt_pkg::t_vec        o_out_z,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [31:0]          i_cfg_data
);

    localparam qrt_pkg::t_quat QUAT_ONE = 16'sd16384;

    // Configuration registers.
    qrt_pkg::t_quat r_quat_w, r_quat_i, r_quat_j, r_quat_k;
    qrt_pkg::t_vec  r_pos_x, r_pos_y, r_pos_z;

    // Pipeline stage registers.
    logic          r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_o_vld;
    logic [1:0]    r_s1_cmd, r_s2_cmd, r_s3_cmd, r_s4_cmd, r_s5_cmd;
    qrt_pkg::t_vec r_s1_vx, r_s1_vy, r_s1_vz;
    qrt_pkg::t_vec r_s2_vx, r_s2_vy, r_s2_vz;
    qrt_pkg::t_vec r_s3_vx, r_s3_vy, r_s3_vz;
    qrt_pkg::t_vec r_s2_tx, r_s2_ty, r_s2_tz;
    qrt_pkg::t_vec r_s3_tx, r_s3_ty, r_s3_tz;
    qrt_pkg::t_vec r_s4_tx, r_s4_ty, r_s4_tz;
    qrt_pkg::t_vec r_s5_tx, r_s5_ty, r_s5_tz;
    qrt_pkg::t_vec r_o_x, r_o_y, r_o_z;
    qrt_pkg::t_vec n_o_x, n_o_y, n_o_z;

    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
    qrt_pkg::t_stage_en row_en;
    qrt_pkg::t_mat      mat;
    qrt_pkg::t_vec      rot_x, rot_y, rot_z;
    logic               s3_add_pos;

    // Clamped sum of translation and vector component.
    function automatic qrt_pkg::t_vec add_sat(input qrt_pkg::t_vec a,
                                              input qrt_pkg::t_vec b);
        logic signed [qrt_pkg::VEC_W:0] s;
        s = (qrt_pkg::VEC_W+1)'(a) + (qrt_pkg::VEC_W+1)'(b);
        if (s[qrt_pkg::VEC_W] == s[qrt_pkg::VEC_W-1]) begin
            return qrt_pkg::t_vec'(s[qrt_pkg::VEC_W-1:0]);
        end else if (s[qrt_pkg::VEC_W]) begin
            return {1'b1, {(qrt_pkg::VEC_W-1){1'b0}}};
        end else begin
            return {1'b0, {(qrt_pkg::VEC_W-1){1'b1}}};
        end
    endfunction

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat_w <= QUAT_ONE;
            r_quat_i <= '0;
            r_quat_j <= '0;
            r_quat_k <= '0;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_pos_z  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                qrt_pkg::REG_QUAT_W: r_quat_w <= qrt_pkg::t_quat'(i_cfg_data[15:0]);
                qrt_pkg::REG_QUAT_I: r_quat_i <= qrt_pkg::t_quat'(i_cfg_data[15:0]);
                qrt_pkg::REG_QUAT_J: r_quat_j <= qrt_pkg::t_quat'(i_cfg_data[15:0]);
                qrt_pkg::REG_QUAT_K: r_quat_k <= qrt_pkg::t_quat'(i_cfg_data[15:0]);
                qrt_pkg::REG_POS_X:  r_pos_x  <= qrt_pkg::t_vec'(i_cfg_data);
                qrt_pkg::REG_POS_Y:  r_pos_y  <= qrt_pkg::t_vec'(i_cfg_data);
                qrt_pkg::REG_POS_Z:  r_pos_z  <= qrt_pkg::t_vec'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // Rotation matrix, rebuilt continuously from the quaternion registers.
    qrt_matrix u_matrix (
        .i_clk    (i_clk),
        .i_quat_w (r_quat_w),
        .i_quat_i (r_quat_i),
        .i_quat_j (r_quat_j),
        .i_quat_k (r_quat_k),
        .o_mat    (mat)
    );

    // A stage may load when it is empty or its contents move on.
    assign rdy6 = !r_o_vld  || !i_stall;
    assign rdy5 = !r_s5_vld || rdy6;
    assign rdy4 = !r_s4_vld || rdy5;
    assign rdy3 = !r_s3_vld || rdy4;
    assign rdy2 = !r_s2_vld || rdy3;
    assign rdy1 = !r_s1_vld || rdy2;
    assign o_stall = !rdy1;

    // Valid bits travel with the items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (rdy1) begin
                r_s1_vld <= i_valid;
            end
            if (rdy2) begin
                r_s2_vld <= r_s1_vld;
            end
            if (rdy3) begin
                r_s3_vld <= r_s2_vld;
            end
            if (rdy4) begin
                r_s4_vld <= r_s3_vld;
            end
            if (rdy5) begin
                r_s5_vld <= r_s4_vld;
            end
            if (rdy6) begin
                r_o_vld <= r_s5_vld;
            end
        end
    end

    // Stage one: capture the item.
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_s1_cmd <= i_cmd;
            r_s1_vx  <= i_vec_x;
            r_s1_vy  <= i_vec_y;
            r_s1_vz  <= i_vec_z;
        end
    end

    // Stage two: the translate-only result.
    always_ff @(posedge i_clk) begin
        if (rdy2) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_vx  <= r_s1_vx;
            r_s2_vy  <= r_s1_vy;
            r_s2_vz  <= r_s1_vz;
            r_s2_tx  <= add_sat(r_pos_x, r_s1_vx);
            r_s2_ty  <= add_sat(r_pos_y, r_s1_vy);
            r_s2_tz  <= add_sat(r_pos_z, r_s1_vz);
        end
    end

    // Stage three: alignment with the matrix builder; items are not held back for a freshly written quaternion.
    always_ff @(posedge i_clk) begin
        if (rdy3) begin
            r_s3_cmd <= r_s2_cmd;
            r_s3_vx  <= r_s2_vx;
            r_s3_vy  <= r_s2_vy;
            r_s3_vz  <= r_s2_vz;
            r_s3_tx  <= r_s2_tx;
            r_s3_ty  <= r_s2_ty;
            r_s3_tz  <= r_s2_tz;
        end
    end

    // Stages four and five: command and translate result ride beside the row units.
    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_s4_cmd <= r_s3_cmd;
            r_s4_tx  <= r_s3_tx;
            r_s4_ty  <= r_s3_ty;
            r_s4_tz  <= r_s3_tz;
        end
        if (rdy5) begin
            r_s5_cmd <= r_s4_cmd;
            r_s5_tx  <= r_s4_tx;
            r_s5_ty  <= r_s4_ty;
            r_s5_tz  <= r_s4_tz;
        end
    end

    assign row_en.s4  = rdy4;
    assign row_en.s5  = rdy5;
    assign s3_add_pos = (r_s3_cmd == qrt_pkg::CMD_POINT);

    // One row unit per output component.
    qrt_row u_row_x (
        .i_clk     (i_clk),
        .i_en      (row_en),
        .i_row     (mat.r0),
        .i_vec_x   (r_s3_vx),
        .i_vec_y   (r_s3_vy),
        .i_vec_z   (r_s3_vz),
        .i_add_pos (s3_add_pos),
        .i_pos     (r_pos_x),
        .o_res     (rot_x)
    );

    qrt_row u_row_y (
        .i_clk     (i_clk),
        .i_en      (row_en),
        .i_row     (mat.r1),
        .i_vec_x   (r_s3_vx),
        .i_vec_y   (r_s3_vy),
        .i_vec_z   (r_s3_vz),
        .i_add_pos (s3_add_pos),
        .i_pos     (r_pos_y),
        .o_res     (rot_y)
    );

    qrt_row u_row_z (
        .i_clk     (i_clk),
        .i_en      (row_en),
        .i_row     (mat.r2),
        .i_vec_x   (r_s3_vx),
        .i_vec_y   (r_s3_vy),
        .i_vec_z   (r_s3_vz),
        .i_add_pos (s3_add_pos),
        .i_pos     (r_pos_z),
        .o_res     (rot_z)
    );

    // Output select by command; the unused command gives zeros.
    always_comb begin
        case (r_s5_cmd)
            qrt_pkg::CMD_POINT, qrt_pkg::CMD_ROT: begin
                n_o_x = rot_x;
                n_o_y = rot_y;
                n_o_z = rot_z;
            end
            qrt_pkg::CMD_TRANS: begin
                n_o_x = r_s5_tx;
                n_o_y = r_s5_ty;
                n_o_z = r_s5_tz;
            end
            default: begin
                n_o_x = '0;
                n_o_y = '0;
                n_o_z = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rdy6) begin
            r_o_x <= n_o_x;
            r_o_y <= n_o_y;
            r_o_z <= n_o_z;
        end
    end

    assign o_valid = r_o_vld;
    assign o_out_x = r_o_x;
    assign o_out_y = r_o_y;
    assign o_out_z = r_o_z;

    // Input stall only when every stage is full and the output is held.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_vld && r_s2_vld && r_s3_vld && r_s4_vld && r_s5_vld
                     && r_o_vld && i_stall))
        else $error("input stalled while the pipeline has room");

    // An item with the unused command leaves as all zeros.
    a_zero_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_vld && rdy6 && r_s5_cmd != qrt_pkg::CMD_POINT
         && r_s5_cmd != qrt_pkg::CMD_ROT && r_s5_cmd != qrt_pkg::CMD_TRANS)
        |=> (o_out_x == '0 && o_out_y == '0 && o_out_z == '0))
        else $error("unused command produced a nonzero result");

    // Translate-only items take the stage-five translate result.
    a_trans_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s5_vld && rdy6 && r_s5_cmd == qrt_pkg::CMD_TRANS)
        |=> (o_out_x == $past(r_s5_tx) && o_out_y == $past(r_s5_ty)
             && o_out_z == $past(r_s5_tz)))
        else $error("translate result lost on the way out");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule
